// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and helpers for the rotation matrix to quaternion block
// widths of the root and divide chains, stage side-band types, saturation
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int SQ_STEPS  = 29;  // root bits of floor(sqrt(a * 2^24))
	localparam int RAD_W     = 58;  // radicand, two bits consumed per cell
	localparam int ROOT_W    = 29;
	localparam int REM_W     = 32;
	localparam int DVD_W     = 56;  // |n| * 2^23 + q/2
	localparam int DIV_STEPS = 56;  // one quotient bit per cell
	localparam int MAG_W     = 33;
	localparam int QUO_W     = 33;
	localparam int HALF_W    = 28;
	localparam int LANES     = 3;

	// component codes
	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Y = 2'd1;
	localparam logic [1:0] COMP_Z = 2'd2;
	localparam logic [1:0] COMP_W = 2'd3;

	typedef struct packed {
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] tz;
		logic [1:0]  diag;
		logic        bad;
		logic [LANES-1:0] neg;
	} pose_t;

	typedef struct packed {
		pose_t                       pose;
		logic [LANES-1:0][MAG_W-1:0] mag;
	} sq_car_t;

	typedef struct packed {
		pose_t             pose;
		logic [HALF_W-1:0] half;
	} dv_car_t;

	// sign and saturate a quotient magnitude to 32 bits
	function automatic logic [31:0] sat_mag(input logic neg, input logic ovf,
		input logic [QUO_W-1:0] quo);
		logic [QUO_W-1:0] m;
		begin
			m = quo;
			if (neg) begin
				if (ovf || (quo > {1'b0, 32'h8000_0000}))
					m = {1'b0, 32'h8000_0000};
				sat_mag = 32'(-m);
			end else begin
				if (ovf || (quo > {1'b0, 32'h7FFF_FFFF}))
					m = {1'b0, 32'h7FFF_FFFF};
				sat_mag = m[31:0];
			end
		end
	endfunction

endpackage

// ===== rtl/rmq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one digit of the square root chain
// takes two radicand bits, decides one root bit, hands on to the next cell
// ----------------------------------------------------------------------------
module rmq_sqrt_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_i,
	input  logic [rmq_pkg::RAD_W-1:0]    rad_i,
	input  logic [rmq_pkg::REM_W-1:0]    rem_i,
	input  logic [rmq_pkg::ROOT_W-1:0]   root_i,
	input  rmq_pkg::sq_car_t             car_i,
	output logic                         valid_q,
	output logic [rmq_pkg::RAD_W-1:0]    rad_q,
	output logic [rmq_pkg::REM_W-1:0]    rem_q,
	output logic [rmq_pkg::ROOT_W-1:0]   root_q,
	output rmq_pkg::sq_car_t             car_q
);

	logic [rmq_pkg::REM_W-1:0] rem_sh;
	logic [rmq_pkg::REM_W-1:0] trial;
	logic                      ge;

	assign rem_sh = {rem_i[rmq_pkg::REM_W-3:0], rad_i[rmq_pkg::RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_i, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= valid_i;
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_i[rmq_pkg::RAD_W-3:0], 2'b00};
		rem_q  <= ge ? (rem_sh - trial) : rem_sh;
		root_q <= {root_i[rmq_pkg::ROOT_W-2:0], ge};
		car_q  <= car_i;
	end

endmodule

// ===== rtl/rmq_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_div_cell: one quotient bit for each of the three divide lanes
// restoring step against the shared root, dividend shifts along the chain
// ----------------------------------------------------------------------------
module rmq_div_cell (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               valid_i,
	input  logic [rmq_pkg::ROOT_W-1:0]                         q_i,
	input  logic [rmq_pkg::LANES-1:0][rmq_pkg::DVD_W-1:0]      dvd_i,
	input  logic [rmq_pkg::LANES-1:0][rmq_pkg::ROOT_W-1:0]     rem_i,
	input  logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]      quo_i,
	input  logic [rmq_pkg::LANES-1:0]                          ovf_i,
	input  rmq_pkg::dv_car_t                                   car_i,
	output logic                                               valid_q,
	output logic [rmq_pkg::ROOT_W-1:0]                         q_q,
	output logic [rmq_pkg::LANES-1:0][rmq_pkg::DVD_W-1:0]      dvd_q,
	output logic [rmq_pkg::LANES-1:0][rmq_pkg::ROOT_W-1:0]     rem_q,
	output logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]      quo_q,
	output logic [rmq_pkg::LANES-1:0]                          ovf_q,
	output rmq_pkg::dv_car_t                                   car_q
);

	logic [rmq_pkg::LANES-1:0][rmq_pkg::ROOT_W:0]   rem_sh;
	logic [rmq_pkg::LANES-1:0][rmq_pkg::ROOT_W:0]   rem_df;
	logic [rmq_pkg::LANES-1:0]                      ge;

	always_comb begin
		for (int l = 0; l < rmq_pkg::LANES; l++) begin
			rem_sh[l] = {rem_i[l], dvd_i[l][rmq_pkg::DVD_W-1]};
			ge[l]     = (rem_sh[l] >= {1'b0, q_i});
			rem_df[l] = rem_sh[l] - {1'b0, q_i};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= valid_i;
	end

	always_ff @(posedge clk) begin
		q_q   <= q_i;
		car_q <= car_i;
		for (int l = 0; l < rmq_pkg::LANES; l++) begin
			dvd_q[l] <= {dvd_i[l][rmq_pkg::DVD_W-2:0], 1'b0};
			rem_q[l] <= ge[l] ? rem_df[l][rmq_pkg::ROOT_W-1:0]
				: rem_sh[l][rmq_pkg::ROOT_W-1:0];
			quo_q[l] <= {quo_i[l][rmq_pkg::QUO_W-2:0], ge[l]};
			ovf_q[l] <= ovf_i[l] | quo_i[l][rmq_pkg::QUO_W-1];
		end
	end

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: pose to quaternion, four-branch trace method
// nine Q8.24 rotation entries in, quaternion x y z w in Q8.24 out, with the
// Q16.16 translation carried alongside
// ----------------------------------------------------------------------------
// usage: a new word may be started on every clock (busy is tied low) and each
// word comes back on done in order; the receiver cannot stall, so results
// must be taken the cycle they appear. the pipeline is one input stage, 29
// square root cells (one root bit each), 56 divide cells (one quotient bit
// each, three lanes sharing the root) and one output register. a non-positive
// root argument gives a zero quaternion with invalid set; oversized components
// saturate to the signed 32-bit range
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] r00,
	input  logic [31:0] r01,
	input  logic [31:0] r02,
	input  logic [31:0] r10,
	input  logic [31:0] r11,
	input  logic [31:0] r12,
	input  logic [31:0] r20,
	input  logic [31:0] r21,
	input  logic [31:0] r22,
	input  logic [31:0] tx_in,
	input  logic [31:0] ty_in,
	input  logic [31:0] tz_in,
	output logic        done,
	output logic [31:0] tx_out,
	output logic [31:0] ty_out,
	output logic [31:0] tz_out,
	output logic [31:0] quat_x,
	output logic [31:0] quat_y,
	output logic [31:0] quat_z,
	output logic [31:0] quat_w,
	output logic        invalid
);

	localparam int SQ = rmq_pkg::SQ_STEPS;
	localparam int DV = rmq_pkg::DIV_STEPS;
	localparam int L  = rmq_pkg::LANES;

	// never stalls: a fresh word every cycle
	assign busy = 1'b0;

	// ---------------- front end: trace, branch pick, root argument ----------
	logic signed [34:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [34:0] trace, arg;
	logic signed [32:0] n0, n1, n2;
	logic [1:0]         diag;
	logic               bad;
	logic [L-1:0][32:0] nv;
	rmq_pkg::sq_car_t   front_car;

	always_comb begin
		e00 = 35'(signed'(r00)); e01 = 35'(signed'(r01)); e02 = 35'(signed'(r02));
		e10 = 35'(signed'(r10)); e11 = 35'(signed'(r11)); e12 = 35'(signed'(r12));
		e20 = 35'(signed'(r20)); e21 = 35'(signed'(r21)); e22 = 35'(signed'(r22));
		trace = e00 + e11 + e22;
		// lanes hold the three off-diagonal components in x, y, z, w order
		// with the diagonal one skipped
		if (trace > 35'sd0) begin
			diag = rmq_pkg::COMP_W;
			arg  = 35'sd16777216 + trace;
			n0   = 33'(e21 - e12);
			n1   = 33'(e02 - e20);
			n2   = 33'(e10 - e01);
		end else if ((e00 > e11) && (e00 > e22)) begin
			diag = rmq_pkg::COMP_X;
			arg  = 35'sd16777216 + e00 - e11 - e22;
			n0   = 33'(e01 + e10);
			n1   = 33'(e02 + e20);
			n2   = 33'(e21 - e12);
		end else if (e11 > e22) begin
			diag = rmq_pkg::COMP_Y;
			arg  = 35'sd16777216 + e11 - e00 - e22;
			n0   = 33'(e01 + e10);
			n1   = 33'(e12 + e21);
			n2   = 33'(e02 - e20);
		end else begin
			diag = rmq_pkg::COMP_Z;
			arg  = 35'sd16777216 + e22 - e00 - e11;
			n0   = 33'(e02 + e20);
			n1   = 33'(e12 + e21);
			n2   = 33'(e10 - e01);
		end
		bad = (arg <= 35'sd0);
		nv[0] = n0;
		nv[1] = n1;
		nv[2] = n2;
		front_car.pose.tx   = tx_in;
		front_car.pose.ty   = ty_in;
		front_car.pose.tz   = tz_in;
		front_car.pose.diag = diag;
		front_car.pose.bad  = bad;
		for (int l = 0; l < L; l++) begin
			front_car.pose.neg[l] = nv[l][32];
			front_car.mag[l]      = nv[l][32] ? 33'(-nv[l]) : nv[l];
		end
	end

	// ---------------- square root chain -------------------------------------
	logic                          sq_v    [0:SQ];
	logic [rmq_pkg::RAD_W-1:0]     sq_rad  [0:SQ];
	logic [rmq_pkg::REM_W-1:0]     sq_rem  [0:SQ];
	logic [rmq_pkg::ROOT_W-1:0]    sq_root [0:SQ];
	rmq_pkg::sq_car_t              sq_car  [0:SQ];

	// input stage: radicand is a * 2^24, forced to zero when a is not positive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_v[0] <= 1'b0;
		else
			sq_v[0] <= start;
	end

	always_ff @(posedge clk) begin
		sq_rad[0] <= bad ? '0 : {1'b0, arg[32:0], 24'b0};
		sq_car[0] <= front_car;
	end

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQ; k++) begin : g_sq
		rmq_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (sq_v[k]),
			.rad_i   (sq_rad[k]),
			.rem_i   (sq_rem[k]),
			.root_i  (sq_root[k]),
			.car_i   (sq_car[k]),
			.valid_q (sq_v[k+1]),
			.rad_q   (sq_rad[k+1]),
			.rem_q   (sq_rem[k+1]),
			.root_q  (sq_root[k+1]),
			.car_q   (sq_car[k+1])
		);
	end

	// ---------------- divide chain ------------------------------------------
	logic                                         dv_v   [0:DV];
	logic [rmq_pkg::ROOT_W-1:0]                   dv_q   [0:DV];
	logic [L-1:0][rmq_pkg::DVD_W-1:0]             dv_dvd [0:DV];
	logic [L-1:0][rmq_pkg::ROOT_W-1:0]            dv_rem [0:DV];
	logic [L-1:0][rmq_pkg::QUO_W-1:0]             dv_quo [0:DV];
	logic [L-1:0]                                 dv_ovf [0:DV];
	rmq_pkg::dv_car_t                             dv_car [0:DV];

	// entry: dividend is |n| * 2^23 plus q/2 for round-half-away rounding;
	// sqrt(a * 2^22) is simply the root halved
	always_comb begin
		dv_v[0]           = sq_v[SQ];
		dv_q[0]           = sq_root[SQ];
		dv_car[0].pose    = sq_car[SQ].pose;
		dv_car[0].half    = sq_root[SQ][rmq_pkg::ROOT_W-1:1];
		dv_rem[0]         = '0;
		dv_quo[0]         = '0;
		dv_ovf[0]         = '0;
		for (int l = 0; l < L; l++)
			dv_dvd[0][l] = {sq_car[SQ].mag[l], 23'b0}
				+ rmq_pkg::DVD_W'(sq_root[SQ][rmq_pkg::ROOT_W-1:1]);
	end

	for (genvar k = 0; k < DV; k++) begin : g_dv
		rmq_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (dv_v[k]),
			.q_i     (dv_q[k]),
			.dvd_i   (dv_dvd[k]),
			.rem_i   (dv_rem[k]),
			.quo_i   (dv_quo[k]),
			.ovf_i   (dv_ovf[k]),
			.car_i   (dv_car[k]),
			.valid_q (dv_v[k+1]),
			.q_q     (dv_q[k+1]),
			.dvd_q   (dv_dvd[k+1]),
			.rem_q   (dv_rem[k+1]),
			.quo_q   (dv_quo[k+1]),
			.ovf_q   (dv_ovf[k+1]),
			.car_q   (dv_car[k+1])
		);
	end

	// ---------------- output: saturate, put lanes back in place -------------
	logic [L-1:0][31:0] lane_val;
	logic [3:0][31:0]   comp;
	logic [1:0]         out_diag;
	logic [31:0]        half_val;

	always_comb begin
		out_diag = dv_car[DV].pose.diag;
		half_val = {4'b0, dv_car[DV].half};
		for (int l = 0; l < L; l++)
			lane_val[l] = rmq_pkg::sat_mag(dv_car[DV].pose.neg[l], dv_ovf[DV][l],
				dv_quo[DV][l]);
		// packed as {w, z, y, x}: the diagonal component takes the halved
		// root, the lanes fill the others in order
		case (out_diag)
			rmq_pkg::COMP_X: comp = {lane_val[2], lane_val[1], lane_val[0], half_val};
			rmq_pkg::COMP_Y: comp = {lane_val[2], lane_val[1], half_val, lane_val[0]};
			rmq_pkg::COMP_Z: comp = {lane_val[2], half_val, lane_val[1], lane_val[0]};
			default:         comp = {half_val, lane_val[2], lane_val[1], lane_val[0]};
		endcase
		if (dv_car[DV].pose.bad)
			comp = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dv_v[DV];
	end

	always_ff @(posedge clk) begin
		tx_out  <= dv_car[DV].pose.tx;
		ty_out  <= dv_car[DV].pose.ty;
		tz_out  <= dv_car[DV].pose.tz;
		quat_x  <= comp[rmq_pkg::COMP_X];
		quat_y  <= comp[rmq_pkg::COMP_Y];
		quat_z  <= comp[rmq_pkg::COMP_Z];
		quat_w  <= comp[rmq_pkg::COMP_W];
		invalid <= dv_car[DV].pose.bad;
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: pose to quaternion conversion check
// drives poses through the command port, predicts each quaternion with an
// exact integer model of the four-branch method and compares every result
// ----------------------------------------------------------------------------
module testbench;

	localparam int LATENCY   = 87;
	localparam int WDOG_MAX  = 2000;
	localparam int N_RANDOM  = 950;
	localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

	// one pose word as presented to the block
	typedef struct {
		logic [31:0] m [9];
		logic [31:0] t [3];
	} pose_word_t;

	// one expected result word
	typedef struct {
		logic [31:0] tx, ty, tz, qx, qy, qz, qw;
		logic        bad;
	} quat_word_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic [31:0] tx_in, ty_in, tz_in;
	logic        done;
	logic [31:0] tx_out, ty_out, tz_out;
	logic [31:0] quat_x, quat_y, quat_z, quat_w;
	logic        invalid;

	pose_word_t  pose_q [$];	// words waiting to be sent
	quat_word_t  quat_q [$];	// predicted results, oldest first
	int          n_errors;
	int          idle_pct;
	int          wdog;
	bit          feeding_done;

	rotation_matrix_to_quaternion u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.r00     (r00),
		.r01     (r01),
		.r02     (r02),
		.r10     (r10),
		.r11     (r11),
		.r12     (r12),
		.r20     (r20),
		.r21     (r21),
		.r22     (r22),
		.tx_in   (tx_in),
		.ty_in   (ty_in),
		.tz_in   (tz_in),
		.done    (done),
		.tx_out  (tx_out),
		.ty_out  (ty_out),
		.tz_out  (tz_out),
		.quat_x  (quat_x),
		.quat_y  (quat_y),
		.quat_z  (quat_z),
		.quat_w  (quat_w),
		.invalid (invalid)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction: exact integer arithmetic in Q.24 units
	// ------------------------------------------------------------------

	// bitwise integer square root, floor
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b, x;
		begin
			r = 0;
			x = v;
			b = 64'd1 << 62;
			while (b > x)
				b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		end
	endfunction

	function automatic logic [31:0] clamp32(input bit neg, input logic [63:0] mag);
		logic [63:0] m;
		begin
			m = mag;
			if (neg) begin
				if (m > 64'h8000_0000)
					m = 64'h8000_0000;
				return 32'(-m);
			end
			if (m > 64'h7FFF_FFFF)
				m = 64'h7FFF_FFFF;
			return m[31:0];
		end
	endfunction

	// n / (2 sqrt(a)), rounded half away from zero; q = floor(sqrt(a * 2^24))
	function automatic logic [31:0] ratio_by_root(input longint n, input logic [63:0] q);
		bit          neg;
		logic [63:0] mag;
		begin
			neg = n < 0;
			mag = neg ? 64'(-n) : 64'(n);
			return clamp32(neg, ((mag << 23) + (q >> 1)) / q);
		end
	endfunction

	function automatic logic [31:0] half_root_q24(input longint a);
		return clamp32(1'b0, int_sqrt(64'(a) << 22));
	endfunction

	function automatic quat_word_t predict_quat(input pose_word_t p);
		longint     d [9];
		longint     trace, a, one;
		logic [63:0] q;
		quat_word_t e;
		begin
			for (int i = 0; i < 9; i++)
				d[i] = longint'($signed(p.m[i]));
			one = longint'(ONE_Q24);
			e.tx = p.t[0];
			e.ty = p.t[1];
			e.tz = p.t[2];
			e.qx = '0; e.qy = '0; e.qz = '0; e.qw = '0;
			e.bad = 1'b0;
			trace = d[0] + d[4] + d[8];
			// d index: 0 m00, 1 m01, 2 m02, 3 m10, 4 m11, 5 m12, 6 m20, 7 m21, 8 m22
			if (trace > 0) begin
				a = one + trace;
				q = int_sqrt(64'(a) << 24);
				e.qw = half_root_q24(a);
				e.qx = ratio_by_root(d[7] - d[5], q);
				e.qy = ratio_by_root(d[2] - d[6], q);
				e.qz = ratio_by_root(d[3] - d[1], q);
			end else if (d[0] > d[4] && d[0] > d[8]) begin
				a = one + d[0] - d[4] - d[8];
				if (a <= 0)
					e.bad = 1'b1;
				else begin
					q = int_sqrt(64'(a) << 24);
					e.qw = ratio_by_root(d[7] - d[5], q);
					e.qx = half_root_q24(a);
					e.qy = ratio_by_root(d[1] + d[3], q);
					e.qz = ratio_by_root(d[2] + d[6], q);
				end
			end else if (d[4] > d[8]) begin
				a = one + d[4] - d[0] - d[8];
				if (a <= 0)
					e.bad = 1'b1;
				else begin
					q = int_sqrt(64'(a) << 24);
					e.qw = ratio_by_root(d[2] - d[6], q);
					e.qx = ratio_by_root(d[1] + d[3], q);
					e.qy = half_root_q24(a);
					e.qz = ratio_by_root(d[5] + d[7], q);
				end
			end else begin
				a = one + d[8] - d[0] - d[4];
				if (a <= 0)
					e.bad = 1'b1;
				else begin
					q = int_sqrt(64'(a) << 24);
					e.qw = ratio_by_root(d[3] - d[1], q);
					e.qx = ratio_by_root(d[2] + d[6], q);
					e.qy = ratio_by_root(d[5] + d[7], q);
					e.qz = half_root_q24(a);
				end
			end
			return e;
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------

	// small signed offset in Q8.24, within +-1.0
	function automatic logic [31:0] near_unit();
		return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
	endfunction

	function automatic logic [31:0] any_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 8)) - 32'd4;
			default: return $urandom();
		endcase
	endfunction

	// build an orthonormal-ish rotation from a random quaternion
	function automatic pose_word_t rotation_pose();
		real        qa [4];
		real        nrm, w, x, y, z;
		real        rm [9];
		pose_word_t p;
		begin
			nrm = 0.0;
			for (int i = 0; i < 4; i++) begin
				qa[i] = $itor($signed($urandom_range(0, 2000))) - 1000.0;
				nrm += qa[i] * qa[i];
			end
			if (nrm == 0.0) begin
				qa[0] = 1.0;
				nrm = 1.0;
			end
			nrm = $sqrt(nrm);
			w = qa[0] / nrm; x = qa[1] / nrm; y = qa[2] / nrm; z = qa[3] / nrm;
			rm[0] = 1 - 2*(y*y + z*z); rm[1] = 2*(x*y - z*w);     rm[2] = 2*(x*z + y*w);
			rm[3] = 2*(x*y + z*w);     rm[4] = 1 - 2*(x*x + z*z); rm[5] = 2*(y*z - x*w);
			rm[6] = 2*(x*z - y*w);     rm[7] = 2*(y*z + x*w);     rm[8] = 1 - 2*(x*x + y*y);
			for (int i = 0; i < 9; i++)
				p.m[i] = 32'($rtoi(rm[i] * 16777216.0));
			for (int i = 0; i < 3; i++)
				p.t[i] = $urandom();
			return p;
		end
	endfunction

	function automatic pose_word_t noise_pose();
		pose_word_t p;
		begin
			for (int i = 0; i < 9; i++)
				p.m[i] = ($urandom_range(0, 1)) ? near_unit() : any_value();
			for (int i = 0; i < 3; i++)
				p.t[i] = any_value();
			return p;
		end
	endfunction

	function automatic pose_word_t diag_pose(input logic [31:0] a0, input logic [31:0] a1,
		input logic [31:0] a2, input logic [31:0] off);
		pose_word_t p;
		begin
			for (int i = 0; i < 9; i++)
				p.m[i] = off;
			p.m[0] = a0; p.m[4] = a1; p.m[8] = a2;
			p.m[1] = ~off; p.m[5] = off ^ 32'h5555_5555;
			p.t[0] = 32'h7FFF_FFFF; p.t[1] = 32'h8000_0000; p.t[2] = $urandom();
			return p;
		end
	endfunction

	// append one word to the pending list
	task automatic add_pose(input pose_word_t p);
		pose_q = {pose_q, p};
	endtask

	// ------------------------------------------------------------------
	// driver: start held while words are pending and the sender is not idling
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			pose_word_t p;
			// a word goes in when start was high and the block was not busy
			if (start && !busy) begin
				quat_q = {quat_q, predict_quat(pose_q.pop_front())};
			end
			if (pose_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				p = pose_q[0];
				start <= 1'b1;
				{r00, r01, r02} <= {p.m[0], p.m[1], p.m[2]};
				{r10, r11, r12} <= {p.m[3], p.m[4], p.m[5]};
				{r20, r21, r22} <= {p.m[6], p.m[7], p.m[8]};
				{tx_in, ty_in, tz_in} <= {p.t[0], p.t[1], p.t[2]};
			end else
				start <= 1'b0;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		n_errors++;
	endtask

	// ------------------------------------------------------------------
	// monitor: each done word is checked against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			quat_word_t e;
			if (quat_q.size() == 0)
				report_mismatch("unexpected word", 32'd0, 32'd0);
			else begin
				e = quat_q.pop_front();
				if (tx_out !== e.tx)   report_mismatch("tx_out", tx_out, e.tx);
				if (ty_out !== e.ty)   report_mismatch("ty_out", ty_out, e.ty);
				if (tz_out !== e.tz)   report_mismatch("tz_out", tz_out, e.tz);
				if (quat_x !== e.qx)   report_mismatch("quat_x", quat_x, e.qx);
				if (quat_y !== e.qy)   report_mismatch("quat_y", quat_y, e.qy);
				if (quat_z !== e.qz)   report_mismatch("quat_z", quat_z, e.qz);
				if (quat_w !== e.qw)   report_mismatch("quat_w", quat_w, e.qw);
				if (invalid !== e.bad) report_mismatch("invalid", 32'(invalid), 32'(e.bad));
			end
		end
	end

	// watchdog: counts cycles with neither a word in nor a word out
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || feeding_done)
			wdog <= 0;
		else if (pose_q.size() > 0 || quat_q.size() > 0) begin
			wdog <= wdog + 1;
			if (wdog >= WDOG_MAX) begin
				$display("watchdog expired at %0t", $time);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence: directed words, then random phases of differing idling
	// ------------------------------------------------------------------
	initial begin
		int phase_pct [4];
		n_errors = 0;
		idle_pct = 0;
		wdog = 0;
		feeding_done = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{r00, r01, r02, r10, r11, r12, r20, r21, r22} = '0;
		{tx_in, ty_in, tz_in} = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// unit diagonal: trace branch with w = 1
		add_pose(diag_pose(ONE_Q24, ONE_Q24, ONE_Q24, 32'd0));
		// smallest positive trace
		add_pose(diag_pose(32'd1, 32'd0, 32'd0, 32'h0000_1234));
		// negative trace falls to a diagonal branch, each axis chosen in turn
		add_pose(diag_pose(ONE_Q24, -ONE_Q24, -ONE_Q24, 32'd0));
		add_pose(diag_pose(-ONE_Q24, ONE_Q24, -ONE_Q24, 32'd0));
		add_pose(diag_pose(-ONE_Q24, -ONE_Q24, ONE_Q24, 32'd0));
		// ties on the diagonal fall to the later entry
		add_pose(diag_pose(32'd0, 32'd0, 32'd0, 32'h0080_0000));
		add_pose(diag_pose(-ONE_Q24, 32'd0, 32'd0, 32'h0010_0000));
		add_pose(diag_pose(32'd0, 32'd0, -ONE_Q24, 32'h0010_0000));
		// large negative diagonal entries; the root argument stays positive
		add_pose(diag_pose(-32'sd10, 32'h8000_0000, -32'sd10, 32'd7));
		add_pose(diag_pose(32'h8000_0000, -32'sd5, 32'h8000_0000, 32'd7));
		add_pose(diag_pose(32'h8000_0000, 32'h8000_0000, -32'sd1, 32'd7));
		add_pose(diag_pose(-ONE_Q24, -ONE_Q24, -ONE_Q24, 32'd0));
		// extreme entries: saturated components and the largest trace
		add_pose(diag_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		add_pose(diag_pose(32'd1, 32'd0, 32'd0, 32'h8000_0000));
		add_pose(diag_pose(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		add_pose(diag_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		add_pose(diag_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		for (int i = 0; i < 4; i++)
			add_pose(rotation_pose());
		wait (pose_q.size() == 0);

		// random phases: no idling, then sender idle 68 of 100, then 20, then none again
		phase_pct = '{0, 68, 20, 0};
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_pct[ph];
			for (int i = 0; i < N_RANDOM / 4; i++)
				add_pose(($urandom_range(0, 99) < 70) ? rotation_pose() : noise_pose());
			wait (pose_q.size() == 0);
		end

		feeding_done = 1;
		for (int c = 0; c < LATENCY * 4 && quat_q.size() > 0; c++)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (quat_q.size() > 0) begin
			$display("%0d results never arrived", quat_q.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== rotation_matrix_to_quaternion.f =====
rtl/rmq_pkg.sv
rtl/rmq_sqrt_cell.sv
rtl/rmq_div_cell.sv
rtl/rotation_matrix_to_quaternion.sv
sim/testbench.sv
